/* src/mbr_pkg.sv */
// Shared types and codes for the MSB-first bit reader
`timescale 1ns / 1ps

package mbr_pkg;

  // widths fixed by the command and result fields
  localparam int SIZE_W = 13;
  localparam int FETCH_W = 13;

  // command codes
  localparam logic [2:0] FUNC_STORE = 3'd0;
  localparam logic [2:0] FUNC_SEEK  = 3'd1;
  localparam logic [2:0] FUNC_SHOW  = 3'd2;
  localparam logic [2:0] FUNC_GET   = 3'd3;
  localparam logic [2:0] FUNC_SKIP  = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_EOS     = 2'd1;
  localparam logic [1:0] STAT_OVERRUN = 2'd2;
  localparam logic [1:0] STAT_SEEK_BAD = 2'd3;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_FILL
  } state_t;

  // one command transfer
  typedef struct packed {
    logic [2:0]  func;
    logic [11:0] byte_addr;
    logic [7:0]  byte_data;
    logic [7:0]  bit_offset;
    logic [5:0]  bit_count;
  } cmd_t;

  // one result transfer
  typedef struct packed {
    logic [31:0] bits;
    logic [5:0]  avail;
    logic [1:0]  status;
  } result_t;

endpackage

/* src/mbr_buffer.sv */
// Stream byte buffer: one write port, one read port, registered read data
`timescale 1ns / 1ps

module mbr_buffer #(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // byte write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // byte read, registered output
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/msb_first_bit_reader_unit.sv */
// MSB-first bit reader over an internal byte buffer, top level
`timescale 1ns / 1ps

// Commands transfer when start is high and busy is low; every command gives
// exactly one result, shown on result for a single cycle with done high, and
// the receiver cannot hold it off. Store, show, a get or skip that stays in
// the current 32-bit word or has already met end of stream, an overrun, a
// failed seek and an unknown code need no refill: the result follows on the
// next cycle and a new command can transfer at once. A good seek, and a get
// or skip that uses up a whole word before end of stream, refill the 64-bit
// window from the buffer one byte per cycle through its single read port:
// such a command fetches at most 8 bytes and holds busy high until the
// result appears. cfg_data sets the stream size in bytes and should be
// written only while the block idles.
module msb_first_bit_reader_unit #(
  parameter int BUF_BYTES = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  mbr_pkg::cmd_t              cmd,
  output logic                       done,
  output mbr_pkg::result_t           result,
  input  logic                       cfg_we,
  input  logic [mbr_pkg::SIZE_W-1:0] cfg_data
);

  import mbr_pkg::*;

  localparam int AW = $clog2(BUF_BYTES);

  state_t               state, state_next;
  logic [63:0]          win, win_next;
  logic [FETCH_W-1:0]   fetch_pos, fetch_pos_next;
  logic [4:0]           bit_pos, bit_pos_next;
  logic [6:0]           valid_bits, valid_bits_next;
  logic                 eos, eos_next;
  logic [SIZE_W-1:0]    stream_size;
  logic                 rd_pending, rd_pending_next;
  logic                 rd_oob, rd_oob_next;
  result_t              res, res_next;
  logic                 done_next;

  // buffer port
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [7:0]           mem_rdata;

  // decode
  logic                 accept;
  logic [5:0]           n;
  logic [63:0]          win_sh;
  logic [31:0]          peek_bits;
  logic [6:0]           left;
  logic [5:0]           avail;
  logic [5:0]           np;
  logic                 overrun;
  logic [FETCH_W-1:0]   seek_pos;
  logic                 seek_ok;
  logic [FETCH_W-1:0]   fetch_a;
  logic [6:0]           valid_a;
  logic                 more;
  logic [7:0]           fill_byte;
  logic                 fill_start;
  logic                 fill_end;

  mbr_buffer #(
    .DEPTH(BUF_BYTES)
  ) u_buffer (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(cmd.byte_data),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign busy   = (state != ST_IDLE);
  assign result = res;

  // command decode, peek and refill step
  always_comb begin
    accept    = start && (state == ST_IDLE);
    n         = (cmd.bit_count > 6'd32) ? 6'd32 : cmd.bit_count;
    win_sh    = win << bit_pos;
    peek_bits = (n == 6'd0) ? 32'd0 : (win_sh[63:32] >> (6'd32 - n));
    left      = (valid_bits > {2'b00, bit_pos}) ? (valid_bits - {2'b00, bit_pos}) : 7'd0;
    avail     = ({1'b0, n} < left) ? n : left[5:0];
    np        = {1'b0, bit_pos} + n;
    overrun   = {1'b0, np} > valid_bits;
    seek_pos  = {1'b0, cmd.byte_addr} + {8'd0, cmd.bit_offset[7:3]};
    seek_ok   = seek_pos < stream_size;
    fetch_a   = rd_pending ? (fetch_pos + 13'd1) : fetch_pos;
    valid_a   = rd_pending ? (valid_bits + 7'd8) : valid_bits;
    more      = (valid_a < 7'd64) && (fetch_a < stream_size);
    fill_byte = rd_oob ? 8'd0 : mem_rdata;
    fill_start = accept && (((cmd.func == FUNC_SEEK) && seek_ok) ||
                 (((cmd.func == FUNC_GET) || (cmd.func == FUNC_SKIP)) &&
                  !overrun && np[5] && !eos));
    fill_end  = (state == ST_FILL) && !more;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (fill_start) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (fill_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and buffer control
  always_comb begin
    win_next        = win;
    fetch_pos_next  = fetch_pos;
    bit_pos_next    = bit_pos;
    valid_bits_next = valid_bits;
    eos_next        = eos;
    res_next        = res;
    done_next       = 1'b0;
    rd_pending_next = 1'b0;
    rd_oob_next     = rd_oob;
    mem_we          = 1'b0;
    mem_waddr       = AW'(cmd.byte_addr);
    mem_re          = 1'b0;
    mem_raddr       = AW'(fetch_a);

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          res_next  = '0;
          done_next = 1'b1;
          unique case (cmd.func)
            FUNC_STORE: begin
              mem_we = (32'(cmd.byte_addr) < BUF_BYTES);
            end
            FUNC_SEEK: begin
              if (!seek_ok) begin
                res_next.status = STAT_SEEK_BAD;
              end else begin
                done_next       = 1'b0;
                eos_next        = 1'b0;
                fetch_pos_next  = seek_pos;
                bit_pos_next    = {2'b00, cmd.bit_offset[2:0]};
                valid_bits_next = 7'd0;
                win_next        = '0;
              end
            end
            FUNC_SHOW: begin
              res_next.bits   = peek_bits;
              res_next.avail  = avail;
              res_next.status = eos ? STAT_EOS : STAT_OK;
            end
            FUNC_GET, FUNC_SKIP: begin
              res_next.bits   = (cmd.func == FUNC_GET) ? peek_bits : 32'd0;
              res_next.avail  = avail;
              res_next.status = eos ? STAT_EOS : STAT_OK;
              if (overrun) begin
                res_next.status = STAT_OVERRUN;
              end else if (!np[5]) begin
                bit_pos_next = np[4:0];
              end else begin
                // word used up: move low half up and refill unless at end
                win_next        = {win[31:0], 32'd0};
                bit_pos_next    = np[4:0];
                valid_bits_next = valid_bits - 7'd32;
                done_next       = eos;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        // land the byte fetched last cycle in the next free lane
        if (rd_pending) begin
          win_next[{~valid_bits[5:3], 3'b000} +: 8] = fill_byte;
        end
        fetch_pos_next  = fetch_a;
        valid_bits_next = valid_a;
        if (more) begin
          mem_re          = 1'b1;
          rd_pending_next = 1'b1;
          rd_oob_next     = (32'(fetch_a) >= BUF_BYTES);
        end else begin
          eos_next        = (fetch_a >= stream_size);
          res_next.status = (fetch_a >= stream_size) ? STAT_EOS : STAT_OK;
          done_next       = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control and reader state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      win         <= '0;
      fetch_pos   <= '0;
      bit_pos     <= '0;
      valid_bits  <= '0;
      eos         <= 1'b0;
      stream_size <= '0;
      rd_pending  <= 1'b0;
      done        <= 1'b0;
    end else begin
      state      <= state_next;
      win        <= win_next;
      fetch_pos  <= fetch_pos_next;
      bit_pos    <= bit_pos_next;
      valid_bits <= valid_bits_next;
      eos        <= eos_next;
      rd_pending <= rd_pending_next;
      done       <= done_next;
      if (cfg_we) begin
        stream_size <= cfg_data;
      end
    end
  end

  // result and fetch payload
  always_ff @(posedge clk) begin
    res    <= res_next;
    rd_oob <= rd_oob_next;
  end

`ifndef SYNTH
  // window fill stays whole bytes and never exceeds two words
  a_valid_bytes: assert property (@(posedge clk) disable iff (rst)
    (valid_bits <= 7'd64) && (valid_bits[2:0] == 3'd0))
    else $error("window valid bit count out of shape");

  // a byte read is only outstanding while filling
  a_pending_fill: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> (state == ST_FILL))
    else $error("buffer read outstanding outside fill");

  // leaving a fill always presents the result
  a_fill_result: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_IDLE) && $past(state == ST_FILL) && $past(!rst)) |-> done)
    else $error("fill ended without a result transfer");

  // no buffer write while a refill reads it
  a_no_write_fill: assert property (@(posedge clk) disable iff (rst)
    busy |-> !mem_we)
    else $error("buffer written during refill");
`endif

endmodule

/* test/tb_msb_first_bit_reader_unit.sv */
// Self-checking testbench for the MSB-first bit reader unit
`timescale 1ns / 1ps

import mbr_pkg::*;

// shadow of the reader state, expected results and result checking
class bit_reader_scoreboard;
  localparam int unsigned BUF_SIZE = 4096;

  bit [7:0]    buf_mem [BUF_SIZE];
  bit          buf_written [BUF_SIZE];
  bit [31:0]   win_hi;
  bit [31:0]   win_lo;
  int unsigned fetch_pos;
  int unsigned bit_pos;
  int unsigned valid_bits;
  bit          at_end;
  int unsigned stream_bytes;
  result_t     expected_results [$];
  int unsigned mismatches;

  function new();
    win_hi = '0;
    win_lo = '0;
    fetch_pos = 0;
    bit_pos = 0;
    valid_bits = 0;
    at_end = 1'b0;
    stream_bytes = 0;
    mismatches = 0;
  endfunction

  function int unsigned pending_count();
    return expected_results.size();
  endfunction

  function bit failed();
    return (mismatches != 0) || (expected_results.size() != 0);
  endfunction

  // pull bytes into the 64-bit window until full or the stream ends
  function void refill_window();
    bit [31:0] b;
    if (fetch_pos >= stream_bytes) begin
      at_end = 1'b1;
      return;
    end
    if (at_end) return;
    while (valid_bits < 64 && fetch_pos < stream_bytes) begin
      b = {24'd0, buf_mem[fetch_pos]};
      fetch_pos++;
      valid_bits += 8;
      if (valid_bits <= 32) win_hi |= b << (32 - valid_bits);
      else win_lo |= b << (64 - valid_bits);
    end
    if (fetch_pos >= stream_bytes) at_end = 1'b1;
  endfunction

  function bit [31:0] peek_bits(int unsigned n);
    bit [31:0] w;
    w = win_hi << bit_pos;
    if (bit_pos != 0) w |= win_lo >> (32 - bit_pos);
    if (n == 0) return '0;
    return w >> (32 - n);
  endfunction

  function int unsigned bits_left(int unsigned n);
    int unsigned left;
    left = (valid_bits > bit_pos) ? valid_bits - bit_pos : 0;
    return (n < left) ? n : left;
  endfunction

  // returns 1 when the request runs past the valid bits
  function bit drop_bits(int unsigned n);
    int unsigned np;
    np = bit_pos + n;
    if (np > valid_bits) return 1'b1;
    if (np < 32) begin
      bit_pos = np;
      return 1'b0;
    end
    win_hi = win_lo;
    win_lo = '0;
    bit_pos = np - 32;
    valid_bits -= 32;
    refill_window();
    return 1'b0;
  endfunction

  function logic [1:0] reader_status();
    return at_end ? STAT_EOS : STAT_OK;
  endfunction

  // buffer bytes that the command would fetch, so the stimulus can write them first
  function void bytes_to_fetch(input cmd_t c, output int unsigned first,
                               output int unsigned count);
    int unsigned cnt;
    int unsigned pos;
    int unsigned vb;
    first = 0;
    count = 0;
    cnt = (c.bit_count > 6'd32) ? 32 : 32'(c.bit_count);
    if (c.func == FUNC_SEEK) begin
      pos = 32'(c.byte_addr) + 32'(c.bit_offset[7:3]);
      if (pos < stream_bytes) begin
        first = pos;
        count = (stream_bytes - pos < 8) ? stream_bytes - pos : 8;
      end
    end else if (c.func == FUNC_GET || c.func == FUNC_SKIP) begin
      if (bit_pos + cnt <= valid_bits && bit_pos + cnt >= 32 &&
          fetch_pos < stream_bytes && !at_end) begin
        vb = valid_bits - 32;
        first = fetch_pos;
        count = (64 - vb) / 8;
        if (stream_bytes - fetch_pos < count) count = stream_bytes - fetch_pos;
      end
    end
  endfunction

  // apply one accepted command and return the result it should give
  function result_t next_result(cmd_t c);
    result_t r;
    int unsigned cnt;
    int unsigned pos;
    r = '0;
    cnt = (c.bit_count > 6'd32) ? 32 : 32'(c.bit_count);
    case (c.func)
      FUNC_STORE: begin
        buf_mem[c.byte_addr] = c.byte_data;
        buf_written[c.byte_addr] = 1'b1;
      end
      FUNC_SEEK: begin
        pos = 32'(c.byte_addr) + 32'(c.bit_offset[7:3]);
        if (pos >= stream_bytes) begin
          r.status = STAT_SEEK_BAD;
        end else begin
          at_end = 1'b0;
          fetch_pos = pos;
          bit_pos = 32'(c.bit_offset[2:0]);
          valid_bits = 0;
          win_hi = '0;
          win_lo = '0;
          refill_window();
          r.status = reader_status();
        end
      end
      FUNC_SHOW: begin
        r.bits = peek_bits(cnt);
        r.avail = 6'(bits_left(cnt));
        r.status = reader_status();
      end
      FUNC_GET, FUNC_SKIP: begin
        if (c.func == FUNC_GET) r.bits = peek_bits(cnt);
        r.avail = 6'(bits_left(cnt));
        r.status = drop_bits(cnt) ? STAT_OVERRUN : reader_status();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function void note_cmd(cmd_t c);
    expected_results.push_back(next_result(c));
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: bits=%h avail=%0d status=%0d",
                 got.bits, got.avail, got.status);
      return;
    end
    want = expected_results.pop_front();
    if (got.bits !== want.bits || got.avail !== want.avail ||
        got.status !== want.status) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected bits=%h avail=%0d status=%0d,",
                 want.bits, want.avail, want.status,
                 " got bits=%h avail=%0d status=%0d",
                 got.bits, got.avail, got.status);
    end
  endfunction
endclass

module tb_msb_first_bit_reader_unit;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned RANDOM_SIZE = 8191;
  localparam int unsigned CMDS_PER_PHASE = 85;
  localparam int unsigned NUM_PHASES = 12;
  localparam int unsigned TAIL_CYCLES = 12;
  localparam logic [2:0] FUNC_RESERVED = 3'd7;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_data = '0;
  logic    busy;
  logic    done;
  result_t result;

  bit          idling_on = 1'b1;
  int unsigned cycle_count = 0;
  bit_reader_scoreboard sb = new();

  msb_first_bit_reader_unit DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  // clock
  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[msb_first_bit_reader_unit] ERROR");
      $finish;
    end
  end

  // result transfers cannot be held off, so every strobe is checked
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  function automatic cmd_t make_cmd(logic [2:0] f, int unsigned addr, int unsigned data,
                                    int unsigned off, int unsigned cnt);
    cmd_t c;
    c.func = f;
    c.byte_addr = addr[11:0];
    c.byte_data = data[7:0];
    c.bit_offset = off[7:0];
    c.bit_count = cnt[5:0];
    return c;
  endfunction

  // one command transfer, then perhaps a short idle burst
  task automatic transfer(cmd_t c);
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    sb.note_cmd(c);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // write any buffer bytes the command would fetch that hold nothing yet
  task automatic issue(cmd_t c);
    int unsigned first;
    int unsigned count;
    sb.bytes_to_fetch(c, first, count);
    for (int unsigned a = first; a < first + count; a++) begin
      if (!sb.buf_written[a]) transfer(make_cmd(FUNC_STORE, a, $urandom, 0, 0));
    end
    transfer(c);
  endtask

  // hold off until every result is in, then write the stream size
  task automatic set_stream_size(int unsigned n_bytes);
    start <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= SIZE_W'(n_bytes);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.stream_bytes = n_bytes;
  endtask

  function automatic cmd_t random_cmd(int unsigned size_now);
    cmd_t c;
    int unsigned sel;
    c.func = FUNC_SHOW;
    c.byte_addr = 12'($urandom);
    c.byte_data = 8'($urandom);
    c.bit_offset = 8'($urandom);
    c.bit_count = 6'($urandom_range(0, 32));
    if ($urandom_range(0, 9) == 0) c.bit_count = 6'($urandom_range(33, 63));
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      c.func = FUNC_STORE;
      if (size_now > 0 && $urandom_range(0, 1) == 0)
        c.byte_addr = 12'($urandom_range(0, size_now - 1));
    end else if (sel < 25) begin
      c.func = FUNC_SEEK;
      // mostly a seek inside the stream, sometimes anywhere at all
      if (size_now > 0 && $urandom_range(0, 7) != 0) begin
        c.byte_addr = 12'($urandom_range(0, size_now - 1));
        c.bit_offset = 8'($urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0) c.bit_offset = 8'($urandom_range(0, 63));
      end
    end else if (sel < 45) begin
      c.func = FUNC_SHOW;
    end else if (sel < 75) begin
      c.func = FUNC_GET;
    end else if (sel < 95) begin
      c.func = FUNC_SKIP;
    end else begin
      c.func = 3'($urandom_range(FUNC_SKIP + 1, FUNC_RESERVED));
    end
    return c;
  endfunction

  initial begin
    bit [7:0]    pattern [12];
    int unsigned fixed_sizes [NUM_PHASES];
    int unsigned size_now;

    pattern = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'h5A, 8'hC3,
                8'h7E, 8'h81, 8'h12, 8'h34, 8'h56, 8'h78};
    fixed_sizes = '{4096, 0, 1, RANDOM_SIZE, 9, 33, 4096, RANDOM_SIZE,
                    300, 4096, 64, RANDOM_SIZE};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: short stream, window edges, overrun, bad seeks, odd codes
    set_stream_size(12);
    for (int unsigned i = 0; i < 12; i++) transfer(make_cmd(FUNC_STORE, i, pattern[i], 0, 0));
    transfer(make_cmd(FUNC_SEEK, 0, 0, 0, 0));
    transfer(make_cmd(FUNC_SHOW, 0, 0, 0, 0));
    transfer(make_cmd(FUNC_SHOW, 0, 0, 0, 32));
    transfer(make_cmd(FUNC_GET, 0, 0, 0, 13));
    transfer(make_cmd(FUNC_SKIP, 0, 0, 0, 63));
    transfer(make_cmd(FUNC_GET, 0, 0, 0, 32));
    transfer(make_cmd(FUNC_SHOW, 0, 0, 0, 32));
    transfer(make_cmd(FUNC_GET, 0, 0, 0, 20));
    transfer(make_cmd(FUNC_SKIP, 0, 0, 0, 19));
    transfer(make_cmd(FUNC_SEEK, 12, 0, 0, 0));
    transfer(make_cmd(FUNC_SEEK, 0, 0, 255, 0));
    transfer(make_cmd(FUNC_SEEK, 2, 0, 13, 0));
    transfer(make_cmd(FUNC_STORE, 4095, 8'hFF, 0, 0));
    transfer(make_cmd(FUNC_RESERVED, 4095, 8'hFF, 255, 63));

    // random phases, each with its own stream size
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      size_now = fixed_sizes[p];
      if (size_now == RANDOM_SIZE) size_now = $urandom_range(2, 4096);
      set_stream_size(size_now);
      idling_on = (p + 1 < NUM_PHASES) && (p % 3 != 2);
      if (size_now > 0)
        issue(make_cmd(FUNC_SEEK, $urandom_range(0, size_now - 1), 0,
                       $urandom_range(0, 7), 0));
      for (int unsigned k = 0; k < CMDS_PER_PHASE; k++) issue(random_cmd(size_now));
    end

    // drain and let any stray result show
    start <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (!sb.failed()) begin
      $display("[msb_first_bit_reader_unit] OK");
    end else begin
      $display("[msb_first_bit_reader_unit] ERROR");
    end
    $finish;
  end
endmodule

/* filelist.f */
src/mbr_pkg.sv
src/mbr_buffer.sv
src/msb_first_bit_reader_unit.sv
test/tb_msb_first_bit_reader_unit.sv
